FILE: rtl/pebt_pkg.sv
// Shared types and constants for the pressure event backoff throttle.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package pebt_pkg;

    localparam int STEP_W    = 24;
    localparam int DECAY_W   = 8;
    localparam int COUNT_W   = 64;
    localparam int SEQ_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DECAY    = 2'd2;

    localparam logic [STEP_W-1:0]  MIN_STEP_RESET = 24'd1000;
    localparam logic [STEP_W-1:0]  MAX_STEP_RESET = 24'd1000000;
    localparam logic [DECAY_W-1:0] DECAY_RESET    = 8'd40;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_SEED = 1'b1;

    typedef struct packed {
        logic [STEP_W-1:0]  min_step_us;
        logic [STEP_W-1:0]  max_step_us;
        logic [DECAY_W-1:0] decay_ticks;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic               modified;
        logic               counts_valid;
        logic [COUNT_W-1:0] high_count;
        logic [COUNT_W-1:0] max_count;
    } item_t;

    typedef struct packed {
        logic [STEP_W-1:0]  throttle_us;
        logic               high_event;
        logic [SEQ_W-1:0]   high_event_number;
        logic               max_event;
        logic [SEQ_W-1:0]   max_event_number;
        logic [COUNT_W-1:0] max_delta;
    } result_t;

endpackage

FILE: rtl/pebt_cfg.sv
// Configuration registers of the throttle: minimum step, maximum step, decay count.
// Depends on pebt_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module pebt_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pebt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pebt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pebt_pkg::cfg_t                   cfg
);

    pebt_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_step_us <= pebt_pkg::MIN_STEP_RESET;
            cfg_reg.max_step_us <= pebt_pkg::MAX_STEP_RESET;
            cfg_reg.decay_ticks <= pebt_pkg::DECAY_RESET;
        end
        else if (cfg_we)
        begin
            // Writes to the unused index are dropped.
            unique case (cfg_index)
                pebt_pkg::CFG_IDX_MIN_STEP: cfg_reg.min_step_us <= cfg_data;
                pebt_pkg::CFG_IDX_MAX_STEP: cfg_reg.max_step_us <= cfg_data;
                pebt_pkg::CFG_IDX_DECAY:
                    cfg_reg.decay_ticks <= cfg_data[pebt_pkg::DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/pebt_core.sv
// Throttle state registers and the single-pass update for one item.
// Depends on pebt_pkg for item_t, result_t, cfg_t and the mode codes.
`timescale 1ns / 1ps

module pebt_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  pebt_pkg::item_t   item,
    input  pebt_pkg::cfg_t    cfg,
    output pebt_pkg::result_t res
);

    logic [pebt_pkg::STEP_W-1:0]  throttle_reg,  throttle_next;
    logic [pebt_pkg::DECAY_W-1:0] quiet_run_reg, quiet_run_next;
    logic [pebt_pkg::COUNT_W-1:0] high_snap_reg, high_snap_next;
    logic [pebt_pkg::COUNT_W-1:0] max_snap_reg,  max_snap_next;
    logic [pebt_pkg::SEQ_W-1:0]   high_seq_reg,  high_seq_next;
    logic [pebt_pkg::SEQ_W-1:0]   max_seq_reg,   max_seq_next;

    logic [pebt_pkg::DECAY_W-1:0] run_inc;
    logic [pebt_pkg::STEP_W-1:0]  halved;
    logic [pebt_pkg::STEP_W-1:0]  step_up;
    logic [pebt_pkg::COUNT_W-1:0] delta;
    logic                         high_rise;
    logic                         max_rise;

    always_comb
    begin
        run_inc   = quiet_run_reg + 1'b1;
        halved    = throttle_reg >> 1;
        high_rise = item.high_count > high_snap_reg;
        max_rise  = item.max_count > max_snap_reg;
        delta     = item.max_count - max_snap_reg;

        // Doubling step, which starts at the minimum and saturates at the maximum.
        priority if (throttle_reg == '0)
            step_up = cfg.min_step_us;
        else if (throttle_reg >= (cfg.max_step_us >> 1))
            step_up = cfg.max_step_us;
        else
            step_up = throttle_reg << 1;
    end

    always_comb
    begin
        throttle_next  = throttle_reg;
        quiet_run_next = quiet_run_reg;
        high_snap_next = high_snap_reg;
        max_snap_next  = max_snap_reg;
        high_seq_next  = high_seq_reg;
        max_seq_next   = max_seq_reg;
        res.high_event = 1'b0;
        res.max_event  = 1'b0;
        res.max_delta  = '0;

        priority if (item.mode == pebt_pkg::MODE_SEED)
        begin
            if (item.counts_valid)
            begin
                high_snap_next = item.high_count;
                max_snap_next  = item.max_count;
            end
        end
        else if (!item.modified)
        begin
            if (throttle_reg != '0)
            begin
                if (run_inc >= cfg.decay_ticks)
                begin
                    throttle_next  = (halved < cfg.min_step_us) ? '0 : halved;
                    quiet_run_next = '0;
                end
                else
                begin
                    quiet_run_next = run_inc;
                end
            end
        end
        else
        begin
            quiet_run_next = '0;
            if (item.counts_valid)
            begin
                if (high_rise)
                begin
                    high_snap_next = item.high_count;
                    high_seq_next  = high_seq_reg + 1'b1;
                    throttle_next  = step_up;
                    res.high_event = 1'b1;
                end
                if (max_rise)
                begin
                    max_snap_next = item.max_count;
                    max_seq_next  = max_seq_reg + 1'b1;
                    res.max_event = 1'b1;
                    res.max_delta = delta;
                end
            end
        end

        res.throttle_us       = throttle_next;
        res.high_event_number = high_seq_next;
        res.max_event_number  = max_seq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_reg  <= '0;
            quiet_run_reg <= '0;
            high_snap_reg <= '0;
            max_snap_reg  <= '0;
            high_seq_reg  <= '0;
            max_seq_reg   <= '0;
        end
        else if (advance)
        begin
            throttle_reg  <= throttle_next;
            quiet_run_reg <= quiet_run_next;
            high_snap_reg <= high_snap_next;
            max_snap_reg  <= max_snap_next;
            high_seq_reg  <= high_seq_next;
            max_seq_reg   <= max_seq_next;
        end
    end

endmodule

FILE: rtl/pressure_event_backoff_throttle.sv
// Top level of the pressure event backoff throttle: input stage, core, result stage.
// Depends on pebt_pkg, pebt_cfg and pebt_core.
`timescale 1ns / 1ps

// Usage:
// Input beats carry mode, modified, counts_valid, high_count and max_count on
// in_valid/in_stall; a beat is taken at a clock edge with in_valid high and
// in_stall low. Each input beat yields exactly one result beat on
// out_valid/out_stall carrying the throttle, the two event flags, the two
// event numbers and the max counter delta.
// An accepted beat lands in the input register; when the result register is
// empty or being taken, the core updates its state and loads the result
// register, which raises out_valid; the result beat can then be taken.
// One beat per cycle is sustained while out_stall stays low; the rate is set
// by the single state update per cycle in the core.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; in_stall rises only when both are full.
// Reset clears the throttle, quiet streak, snapshots and event numbers to zero,
// empties both registers and loads the configuration reset values.
// Configuration writes on cfg_we/cfg_index/cfg_data take effect at the next
// edge and are meant for idle periods only; index 3 is ignored.

module pressure_event_backoff_throttle (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pebt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pebt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic                             modified,
    input  logic                             counts_valid,
    input  logic [pebt_pkg::COUNT_W-1:0]     high_count,
    input  logic [pebt_pkg::COUNT_W-1:0]     max_count,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pebt_pkg::STEP_W-1:0]      throttle_us,
    output logic                             high_event,
    output logic [pebt_pkg::SEQ_W-1:0]       high_event_number,
    output logic                             max_event,
    output logic [pebt_pkg::SEQ_W-1:0]       max_event_number,
    output logic [pebt_pkg::COUNT_W-1:0]     max_delta
);

    pebt_pkg::cfg_t    cfg;
    pebt_pkg::item_t   item_reg;
    pebt_pkg::result_t res;
    pebt_pkg::result_t res_reg;

    logic in_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    pebt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pebt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_take || (in_valid_reg && !advance);
            out_valid_reg <= advance || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.mode         <= mode;
            item_reg.modified     <= modified;
            item_reg.counts_valid <= counts_valid;
            item_reg.high_count   <= high_count;
            item_reg.max_count    <= max_count;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign throttle_us       = res_reg.throttle_us;
    assign high_event        = res_reg.high_event;
    assign high_event_number = res_reg.high_event_number;
    assign max_event         = res_reg.max_event;
    assign max_event_number  = res_reg.max_event_number;
    assign max_delta         = res_reg.max_delta;

endmodule

FILE: rtl/pebt_checker.sv
// Port-level checks for the pressure event backoff throttle, bound to the top level.
// Depends on pebt_pkg for field widths.
`timescale 1ns / 1ps

module pebt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [pebt_pkg::STEP_W-1:0]      throttle_us,
    input logic                             high_event,
    input logic [pebt_pkg::SEQ_W-1:0]       high_event_number,
    input logic                             max_event,
    input logic [pebt_pkg::SEQ_W-1:0]       max_event_number,
    input logic [pebt_pkg::COUNT_W-1:0]     max_delta
);

    logic                         seen_reg;
    logic [pebt_pkg::SEQ_W-1:0]   last_high_reg;
    logic [pebt_pkg::SEQ_W-1:0]   last_max_reg;

    // Event numbers of the last delivered beat, to check the running count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            last_high_reg <= '0;
            last_max_reg  <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            seen_reg      <= 1'b1;
            last_high_reg <= high_event_number;
            last_max_reg  <= max_event_number;
        end
    end

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(throttle_us)
            && $stable(high_event_number) && $stable(max_delta))
        else $error("stalled result beat changed");

    a_delta_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (max_event == (max_delta != '0)))
        else $error("max delta disagrees with max event flag");

    a_high_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |->
            high_event_number == last_high_reg + {{(pebt_pkg::SEQ_W-1){1'b0}}, high_event})
        else $error("high event number does not follow the event flag");

    a_max_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |->
            max_event_number == last_max_reg + {{(pebt_pkg::SEQ_W-1){1'b0}}, max_event})
        else $error("max event number does not follow the event flag");

endmodule

bind pressure_event_backoff_throttle pebt_checker u_pebt_checker (.*);
